// ===== rtl/ebcm_pkg.sv =====
// shared constants, codes and types for the extent buffer cache manager
// no dependencies; used by ebcm_age_table and extent_buffer_cache_manager_unit
package ebcm_pkg;

    localparam int NUM_ENTRIES        = 16;
    localparam int SLOT_W             = 4;
    localparam int MAX_EXTENT_SECTORS = 64;
    localparam int LEN_W              = 7;
    localparam int ADDR_W             = 32;
    localparam int LOCK_W             = 8;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    // request opcodes
    localparam logic [3:0] OP_FIND       = 4'd0;
    localparam logic [3:0] OP_RESIZE     = 4'd1;
    localparam logic [3:0] OP_ACCESS     = 4'd2;
    localparam logic [3:0] OP_MARK_DIRTY = 4'd3;
    localparam logic [3:0] OP_LOCK       = 4'd4;
    localparam logic [3:0] OP_UNLOCK     = 4'd5;
    localparam logic [3:0] OP_WB_ONE     = 4'd6;
    localparam logic [3:0] OP_INVALIDATE = 4'd7;
    localparam logic [3:0] OP_WB_ALL     = 4'd8;

    // closing status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_CACHED = 3'd1;
    localparam logic [2:0] ST_NO_ROOM    = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
    localparam logic [2:0] ST_RANGE      = 3'd4;
    localparam logic [2:0] ST_LOCK_ERR   = 3'd5;

    // disk commands
    localparam logic [1:0] DISK_NONE  = 2'd0;
    localparam logic [1:0] DISK_READ  = 2'd1;
    localparam logic [1:0] DISK_WRITE = 2'd2;

    // recency table command
    typedef struct packed {
        logic              promote;
        logic [SLOT_W-1:0] slot;
    } age_cmd_t;

endpackage

// ===== rtl/ebcm_age_table.sv =====
// recency rank table: rank 0 is newest, ranks always form a permutation of slots
// depends on ebcm_pkg
module ebcm_age_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ebcm_pkg::age_cmd_t          cmd,
    input  logic [ebcm_pkg::SLOT_W-1:0] rd_slot,
    output logic [ebcm_pkg::SLOT_W-1:0] rd_rank,
    input  logic [ebcm_pkg::SLOT_W-1:0] query_rank,
    output logic [ebcm_pkg::SLOT_W-1:0] match_slot
);

    logic [ebcm_pkg::SLOT_W-1:0] rank_reg [ebcm_pkg::NUM_ENTRIES];
    logic [ebcm_pkg::SLOT_W-1:0] promo_rank;

    assign rd_rank    = rank_reg[rd_slot];
    assign promo_rank = rank_reg[cmd.slot];

    // slot holding the queried rank
    always_comb begin
        match_slot = '0;
        for (int i = 0; i < ebcm_pkg::NUM_ENTRIES; i++) begin
            if (rank_reg[i] == query_rank) begin
                match_slot = ebcm_pkg::SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ebcm_pkg::NUM_ENTRIES; i++) begin
                rank_reg[i] <= ebcm_pkg::SLOT_W'(i);
            end
        end else if (cmd.promote) begin
            for (int i = 0; i < ebcm_pkg::NUM_ENTRIES; i++) begin
                if (ebcm_pkg::SLOT_W'(i) == cmd.slot) begin
                    rank_reg[i] <= '0;
                end else if (rank_reg[i] < promo_rank) begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/extent_buffer_cache_manager_unit.sv =====
// top level of the extent buffer cache manager: request sequencer, entry table, ports
// depends on ebcm_pkg and ebcm_age_table
//
// An LRU cache directory for up to 16 variable-length extents (1..64 sectors each).
// One request enters on the s_ stream; it produces zero or more disk command
// transactions (read or write, last low) followed by exactly one closing transaction
// with last high on the m_ stream. The block takes one request at a time and is not
// ready until the closing result is placed in the output register; a result may wait
// there while the next request is accepted. A small sequencer walks the 16 slots one
// per cycle through a single compare path for a lookup or a victim scan; evictions,
// write back all and invalidate probes add further walks, and the sequencer waits
// before each disk command or the closing result while the output
// is stalled. capacity_sectors is written through the
// APB port at address 0 and must only change while no request is in flight.
module extent_buffer_cache_manager_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // start_sector[31:0], sector_count[47:32],
                                   // sector_offset[53:48], fill_on_grow[54]
    input  logic [3:0]  s_tuser,   // opcode[3:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // disk_sector[31:0], disk_count[38:32],
                                   // entry_slot[42:39], status[45:43]
    output logic [1:0]  m_tuser,   // disk_op[1:0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = ebcm_pkg::SLOT_W;
    localparam int LW = ebcm_pkg::LEN_W;
    localparam int AW = ebcm_pkg::ADDR_W;
    localparam int NE = ebcm_pkg::NUM_ENTRIES;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NE - 1);
    localparam logic [AW-1:0] PROBE_STEP = AW'(ebcm_pkg::MAX_EXTENT_SECTORS);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOOK, S_RESOLVE, S_FIT, S_VSCAN, S_VDONE, S_EVICT,
        S_RFIT, S_GROW, S_FREE, S_WBA_FIND, S_WBA_DO, S_CLOSE
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] cap_reg;

    // latched request
    logic [3:0]    op_reg;
    logic [AW-1:0] key_reg;
    logic [15:0]   cnt_reg;
    logic [5:0]    off_reg;
    logic          fill_reg;

    // sequencer working registers
    logic [SW-1:0] ptr_reg;      // the single entry read address
    logic [SW-1:0] tgt_reg;      // slot hit by the lookup
    logic          found_reg;
    logic [SW-1:0] best_reg;     // eviction candidate
    logic [SW-1:0] best_rank_reg;
    logic          have_best_reg;
    logic [16:0]   need_reg;     // sectors held after a resize
    logic [10:0]   k_reg;        // probe index or age rank walk
    logic [10:0]   probes_reg;
    logic [SW-1:0] close_slot_reg;
    logic [2:0]    close_st_reg;

    // entry table
    logic [NE-1:0]     valid_reg;
    logic [NE-1:0]     first_reg;
    logic [NE-1:0]     all_reg;
    logic [NE-1:0]     dirty_reg;
    logic [AW-1:0]     start_reg [NE];
    logic [LW-1:0]     len_reg   [NE];
    logic [7:0]        lock_reg  [NE];
    logic [15:0]       held_reg;

    // output register
    logic          out_valid_reg;
    logic [1:0]    out_op_reg;
    logic [AW-1:0] out_sector_reg;
    logic [LW-1:0] out_count_reg;
    logic [SW-1:0] out_slot_reg;
    logic [2:0]    out_st_reg;
    logic          out_last_reg;

    // entry read at ptr
    logic [AW-1:0] rd_start;
    logic [LW-1:0] rd_len;
    logic [7:0]    rd_lock;
    logic          rd_valid, rd_first, rd_all, rd_dirty;
    logic [SW-1:0] rd_rank;
    logic [SW-1:0] match_slot;

    ebcm_pkg::age_cmd_t age_cmd;

    logic out_free;
    logic size_bad;
    logic over_range;
    logic first_only;
    logic acc_read;
    logic wb_emit;
    logic res_emit;
    logic res_go;
    logic fit_over;
    logic candidate;
    logic [LW-1:0] wr_count;
    logic grow_emit;

    assign rd_start = start_reg[ptr_reg];
    assign rd_len   = len_reg[ptr_reg];
    assign rd_lock  = lock_reg[ptr_reg];
    assign rd_valid = valid_reg[ptr_reg];
    assign rd_first = first_reg[ptr_reg];
    assign rd_all   = all_reg[ptr_reg];
    assign rd_dirty = dirty_reg[ptr_reg];

    assign out_free = !out_valid_reg || m_tready;

    // decode helpers
    assign size_bad   = (cnt_reg == 16'd0) ||
                        (cnt_reg > 16'(ebcm_pkg::MAX_EXTENT_SECTORS));
    assign over_range = (17'(off_reg) + 17'(cnt_reg)) > 17'(rd_len);
    assign first_only = (off_reg == 6'd0) && (cnt_reg == 16'd1);
    assign acc_read   = (op_reg == ebcm_pkg::OP_ACCESS) && found_reg && !over_range &&
                        (first_only ? !rd_first : !rd_all);
    assign wb_emit    = (op_reg == ebcm_pkg::OP_WB_ONE) && found_reg && rd_dirty;
    assign res_emit   = acc_read || wb_emit;
    assign res_go     = !res_emit || out_free;
    assign wr_count   = rd_all ? rd_len : LW'(1);
    assign grow_emit  = fill_reg && (cnt_reg[LW-1:0] > rd_len);

    // room check for a find miss
    assign fit_over = ((17'(held_reg) + 17'(cnt_reg)) > 17'(cap_reg)) || (&valid_reg);

    // oldest unlocked entry, never the resized extent itself
    assign candidate = rd_valid && (rd_lock == 8'd0) &&
                       !((op_reg == ebcm_pkg::OP_RESIZE) && (ptr_reg == tgt_reg)) &&
                       (!have_best_reg || (rd_rank > best_rank_reg));

    // recency promotion on access, resize hit and install
    always_comb begin
        age_cmd.slot    = ptr_reg;
        age_cmd.promote = 1'b0;
        if (state_reg == S_RESOLVE && res_go && found_reg) begin
            if (op_reg == ebcm_pkg::OP_RESIZE ||
                (op_reg == ebcm_pkg::OP_ACCESS && !over_range)) begin
                age_cmd.promote = 1'b1;
            end
        end else if (state_reg == S_FREE && !rd_valid) begin
            age_cmd.promote = 1'b1;
        end
    end

    ebcm_age_table u_age (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (age_cmd),
        .rd_slot    (ptr_reg),
        .rd_rank    (rd_rank),
        .query_rank (k_reg[SW-1:0]),
        .match_slot (match_slot)
    );

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_st_reg, out_slot_reg, out_count_reg, out_sector_reg};
    assign m_tuser  = out_op_reg;
    assign m_tlast  = out_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'd0, cap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cap_reg       <= ebcm_pkg::CAPACITY_RESET;
            valid_reg     <= '0;
            first_reg     <= '0;
            all_reg       <= '0;
            dirty_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NE; i++) begin
                lock_reg[i] <= '0;
            end
        end else begin
            // register write
            if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
                cap_reg <= pwdata[15:0];
            end

            // output handoff, a new emit below overrides
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= s_tuser;
                        key_reg  <= s_tdata[31:0];
                        cnt_reg  <= s_tdata[47:32];
                        off_reg  <= s_tdata[53:48];
                        fill_reg <= s_tdata[54];
                        state_reg <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    ptr_reg <= '0;
                    k_reg   <= '0;
                    // probe count is ceil(count / max extent), at least one
                    probes_reg <= {1'b0, cnt_reg[15:6]} + 11'(|cnt_reg[5:0]);
                    case (op_reg)
                        ebcm_pkg::OP_FIND, ebcm_pkg::OP_RESIZE: begin
                            if (size_bad) begin
                                close_slot_reg <= '0;
                                close_st_reg   <= ebcm_pkg::ST_BAD_SIZE;
                                state_reg      <= S_CLOSE;
                            end else begin
                                state_reg <= S_LOOK;
                            end
                        end
                        ebcm_pkg::OP_ACCESS, ebcm_pkg::OP_MARK_DIRTY, ebcm_pkg::OP_LOCK,
                        ebcm_pkg::OP_UNLOCK, ebcm_pkg::OP_WB_ONE,
                        ebcm_pkg::OP_INVALIDATE: begin
                            state_reg <= S_LOOK;
                        end
                        ebcm_pkg::OP_WB_ALL: begin
                            state_reg <= S_WBA_FIND;
                        end
                        default: begin
                            close_slot_reg <= '0;
                            close_st_reg   <= ebcm_pkg::ST_OK;
                            state_reg      <= S_CLOSE;
                        end
                    endcase
                end

                // lowest slot whose start matches
                S_LOOK: begin
                    if (rd_valid && (rd_start == key_reg)) begin
                        found_reg <= 1'b1;
                        tgt_reg   <= ptr_reg;
                        state_reg <= S_RESOLVE;
                    end else if (ptr_reg == LAST_SLOT) begin
                        found_reg <= 1'b0;
                        state_reg <= S_RESOLVE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                S_RESOLVE: begin
                    if (res_go) begin
                        close_slot_reg <= found_reg ? ptr_reg : '0;
                        close_st_reg   <= found_reg ? ebcm_pkg::ST_OK
                                                    : ebcm_pkg::ST_NOT_CACHED;
                        state_reg      <= S_CLOSE;
                        case (op_reg)
                            ebcm_pkg::OP_FIND: begin
                                if (!found_reg) begin
                                    state_reg <= S_FIT;
                                end
                            end
                            ebcm_pkg::OP_RESIZE: begin
                                if (found_reg && (cnt_reg[LW-1:0] != rd_len)) begin
                                    need_reg  <= 17'(held_reg) - 17'(rd_len) + 17'(cnt_reg);
                                    state_reg <= S_RFIT;
                                end
                            end
                            ebcm_pkg::OP_ACCESS: begin
                                if (found_reg && over_range) begin
                                    close_st_reg <= ebcm_pkg::ST_RANGE;
                                end
                                if (acc_read) begin
                                    out_valid_reg  <= 1'b1;
                                    out_op_reg     <= ebcm_pkg::DISK_READ;
                                    out_sector_reg <= rd_start;
                                    out_count_reg  <= first_only ? LW'(1) : rd_len;
                                    out_slot_reg   <= ptr_reg;
                                    out_st_reg     <= ebcm_pkg::ST_OK;
                                    out_last_reg   <= 1'b0;
                                    first_reg[ptr_reg] <= 1'b1;
                                    if (!first_only) begin
                                        all_reg[ptr_reg] <= 1'b1;
                                    end
                                end
                            end
                            ebcm_pkg::OP_MARK_DIRTY: begin
                                if (found_reg) begin
                                    dirty_reg[ptr_reg] <= 1'b1;
                                end
                            end
                            ebcm_pkg::OP_LOCK: begin
                                if (found_reg) begin
                                    if (rd_lock == 8'hFF) begin
                                        close_st_reg <= ebcm_pkg::ST_LOCK_ERR;
                                    end else begin
                                        lock_reg[ptr_reg] <= rd_lock + 1'b1;
                                    end
                                end
                            end
                            ebcm_pkg::OP_UNLOCK: begin
                                if (found_reg) begin
                                    if (rd_lock == 8'h00) begin
                                        close_st_reg <= ebcm_pkg::ST_LOCK_ERR;
                                    end else begin
                                        lock_reg[ptr_reg] <= rd_lock - 1'b1;
                                    end
                                end
                            end
                            ebcm_pkg::OP_WB_ONE: begin
                                if (wb_emit) begin
                                    out_valid_reg  <= 1'b1;
                                    out_op_reg     <= ebcm_pkg::DISK_WRITE;
                                    out_sector_reg <= rd_start;
                                    out_count_reg  <= wr_count;
                                    out_slot_reg   <= ptr_reg;
                                    out_st_reg     <= ebcm_pkg::ST_OK;
                                    out_last_reg   <= 1'b0;
                                    dirty_reg[ptr_reg] <= 1'b0;
                                end
                            end
                            ebcm_pkg::OP_INVALIDATE: begin
                                // drop without write back, even when locked
                                if (found_reg) begin
                                    valid_reg[ptr_reg] <= 1'b0;
                                    first_reg[ptr_reg] <= 1'b0;
                                    all_reg[ptr_reg]   <= 1'b0;
                                    dirty_reg[ptr_reg] <= 1'b0;
                                    lock_reg[ptr_reg]  <= '0;
                                    held_reg <= held_reg - 16'(rd_len);
                                end
                                close_slot_reg <= '0;
                                close_st_reg   <= ebcm_pkg::ST_OK;
                                if ((k_reg + 1'b1) < probes_reg) begin
                                    k_reg     <= k_reg + 1'b1;
                                    key_reg   <= key_reg + PROBE_STEP;
                                    ptr_reg   <= '0;
                                    state_reg <= S_LOOK;
                                end
                            end
                            default: begin
                                close_slot_reg <= '0;
                                close_st_reg   <= ebcm_pkg::ST_OK;
                            end
                        endcase
                    end
                end

                // find miss: evict until the extent fits and a slot is free
                S_FIT: begin
                    ptr_reg       <= '0;
                    have_best_reg <= 1'b0;
                    state_reg     <= fit_over ? S_VSCAN : S_FREE;
                end

                S_RFIT: begin
                    if (need_reg > 17'(cap_reg)) begin
                        ptr_reg       <= '0;
                        have_best_reg <= 1'b0;
                        state_reg     <= S_VSCAN;
                    end else begin
                        ptr_reg   <= tgt_reg;
                        state_reg <= S_GROW;
                    end
                end

                S_VSCAN: begin
                    if (candidate) begin
                        best_reg      <= ptr_reg;
                        best_rank_reg <= rd_rank;
                        have_best_reg <= 1'b1;
                    end
                    if (ptr_reg == LAST_SLOT) begin
                        state_reg <= S_VDONE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                S_VDONE: begin
                    if (!have_best_reg) begin
                        close_slot_reg <= (op_reg == ebcm_pkg::OP_RESIZE) ? tgt_reg : '0;
                        close_st_reg   <= ebcm_pkg::ST_NO_ROOM;
                        state_reg      <= S_CLOSE;
                    end else begin
                        ptr_reg   <= best_reg;
                        state_reg <= S_EVICT;
                    end
                end

                // write back if dirty, then free the victim
                S_EVICT: begin
                    if (!rd_dirty || out_free) begin
                        if (rd_dirty) begin
                            out_valid_reg  <= 1'b1;
                            out_op_reg     <= ebcm_pkg::DISK_WRITE;
                            out_sector_reg <= rd_start;
                            out_count_reg  <= wr_count;
                            out_slot_reg   <= ptr_reg;
                            out_st_reg     <= ebcm_pkg::ST_OK;
                            out_last_reg   <= 1'b0;
                        end
                        valid_reg[ptr_reg] <= 1'b0;
                        first_reg[ptr_reg] <= 1'b0;
                        all_reg[ptr_reg]   <= 1'b0;
                        dirty_reg[ptr_reg] <= 1'b0;
                        lock_reg[ptr_reg]  <= '0;
                        held_reg <= held_reg - 16'(rd_len);
                        need_reg <= need_reg - 17'(rd_len);
                        state_reg <= (op_reg == ebcm_pkg::OP_RESIZE) ? S_RFIT : S_FIT;
                    end
                end

                // resize commit, reading the added sectors when asked
                S_GROW: begin
                    if (!grow_emit || out_free) begin
                        if (grow_emit) begin
                            out_valid_reg  <= 1'b1;
                            out_op_reg     <= ebcm_pkg::DISK_READ;
                            out_sector_reg <= rd_start + AW'(rd_len);
                            out_count_reg  <= cnt_reg[LW-1:0] - rd_len;
                            out_slot_reg   <= ptr_reg;
                            out_st_reg     <= ebcm_pkg::ST_OK;
                            out_last_reg   <= 1'b0;
                        end
                        len_reg[ptr_reg] <= cnt_reg[LW-1:0];
                        held_reg       <= need_reg[15:0];
                        close_slot_reg <= ptr_reg;
                        close_st_reg   <= ebcm_pkg::ST_OK;
                        state_reg      <= S_CLOSE;
                    end
                end

                // install in the lowest free slot
                S_FREE: begin
                    if (!rd_valid) begin
                        valid_reg[ptr_reg] <= 1'b1;
                        first_reg[ptr_reg] <= 1'b0;
                        all_reg[ptr_reg]   <= 1'b0;
                        dirty_reg[ptr_reg] <= 1'b0;
                        lock_reg[ptr_reg]  <= '0;
                        start_reg[ptr_reg] <= key_reg;
                        len_reg[ptr_reg]   <= cnt_reg[LW-1:0];
                        held_reg       <= held_reg + cnt_reg;
                        close_slot_reg <= ptr_reg;
                        close_st_reg   <= ebcm_pkg::ST_OK;
                        state_reg      <= S_CLOSE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                // write back all, newest to oldest
                S_WBA_FIND: begin
                    ptr_reg   <= match_slot;
                    state_reg <= S_WBA_DO;
                end

                S_WBA_DO: begin
                    if (!(rd_valid && rd_dirty) || out_free) begin
                        if (rd_valid && rd_dirty) begin
                            out_valid_reg  <= 1'b1;
                            out_op_reg     <= ebcm_pkg::DISK_WRITE;
                            out_sector_reg <= rd_start;
                            out_count_reg  <= wr_count;
                            out_slot_reg   <= ptr_reg;
                            out_st_reg     <= ebcm_pkg::ST_OK;
                            out_last_reg   <= 1'b0;
                            dirty_reg[ptr_reg] <= 1'b0;
                        end
                        if (k_reg[SW-1:0] == LAST_SLOT) begin
                            close_slot_reg <= '0;
                            close_st_reg   <= ebcm_pkg::ST_OK;
                            state_reg      <= S_CLOSE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_WBA_FIND;
                        end
                    end
                end

                S_CLOSE: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_op_reg     <= ebcm_pkg::DISK_NONE;
                        out_sector_reg <= '0;
                        out_count_reg  <= '0;
                        out_slot_reg   <= close_slot_reg;
                        out_st_reg     <= close_st_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/ebcm_result_checker.sv =====
// result checker for the extent buffer cache manager: predicts and compares every result
// depends on ebcm_pkg; instantiated beside the block by extent_buffer_cache_manager_unit_test
module ebcm_result_checker
    import ebcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        disk_op;
        logic [ADDR_W-1:0] disk_sector;
        logic [LEN_W-1:0]  disk_count;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        status;
        logic              last;
    } cache_result_t;

    cache_result_t expected_results[$];

    logic [15:0]       capacity;
    logic [15:0]       held;
    logic              valid_q  [NUM_ENTRIES];
    logic [ADDR_W-1:0] start_q  [NUM_ENTRIES];
    logic [LEN_W-1:0]  len_q    [NUM_ENTRIES];
    logic              first_q  [NUM_ENTRIES];
    logic              whole_q  [NUM_ENTRIES];
    logic              dirty_q  [NUM_ENTRIES];
    logic [LOCK_W-1:0] locks_q  [NUM_ENTRIES];
    logic [SLOT_W-1:0] rank_q   [NUM_ENTRIES];

    function automatic void push_result(logic [1:0] op, logic [ADDR_W-1:0] sec,
                                        int cnt, int slot, logic [2:0] st, logic last);
        cache_result_t r;
        r.disk_op = op;
        r.disk_sector = sec;
        r.disk_count = LEN_W'(cnt);
        r.slot = SLOT_W'(slot);
        r.status = st;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic int lookup_extent(logic [ADDR_W-1:0] sec);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (valid_q[i] && start_q[i] == sec) return i;
        return -1;
    endfunction

    function automatic void make_newest(int s);
        logic [SLOT_W-1:0] r;
        r = rank_q[s];
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (rank_q[i] < r) rank_q[i]++;
        rank_q[s] = '0;
    endfunction

    function automatic void drop_entry(int s);
        valid_q[s] = 0;
        first_q[s] = 0;
        whole_q[s] = 0;
        dirty_q[s] = 0;
        locks_q[s] = '0;
        held = held - 16'(len_q[s]);
    endfunction

    function automatic void write_back_entry(int s);
        if (!dirty_q[s]) return;
        push_result(DISK_WRITE, start_q[s], whole_q[s] ? int'(len_q[s]) : 1, s, ST_OK, 0);
        dirty_q[s] = 0;
    endfunction

    function automatic int oldest_unlocked(int skip);
        int best;
        best = -1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (i == skip || !valid_q[i] || locks_q[i] != 0) continue;
            if (best < 0 || rank_q[i] > rank_q[best]) best = i;
        end
        return best;
    endfunction

    function automatic bit slot_free();
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (!valid_q[i]) return 1;
        return 0;
    endfunction

    function automatic void clear_table();
        capacity = CAPACITY_RESET;
        held = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            valid_q[i] = 0;
            start_q[i] = '0;
            len_q[i] = '0;
            first_q[i] = 0;
            whole_q[i] = 0;
            dirty_q[i] = 0;
            locks_q[i] = '0;
            rank_q[i] = SLOT_W'(i);
        end
    endfunction

    // works out every result that one request causes and updates the table copy
    function automatic void predict_request(logic [3:0] op, logic [ADDR_W-1:0] sec,
                                            logic [15:0] cnt, logic [5:0] off, logic fill);
        int s, v, need, probes;
        if (op == OP_FIND || op == OP_RESIZE) begin
            if (cnt == 0 || cnt > MAX_EXTENT_SECTORS) begin
                push_result(DISK_NONE, '0, 0, 0, ST_BAD_SIZE, 1);
                return;
            end
        end
        case (op)
            OP_FIND: begin
                s = lookup_extent(sec);
                if (s >= 0) begin
                    push_result(DISK_NONE, '0, 0, s, ST_OK, 1);
                    return;
                end
                while (int'(held) + int'(cnt) > int'(capacity) || !slot_free()) begin
                    v = oldest_unlocked(-1);
                    if (v < 0) begin
                        push_result(DISK_NONE, '0, 0, 0, ST_NO_ROOM, 1);
                        return;
                    end
                    write_back_entry(v);
                    drop_entry(v);
                end
                s = 0;
                while (valid_q[s]) s++;
                valid_q[s] = 1;
                start_q[s] = sec;
                len_q[s] = LEN_W'(cnt);
                first_q[s] = 0;
                whole_q[s] = 0;
                dirty_q[s] = 0;
                locks_q[s] = '0;
                make_newest(s);
                held = held + cnt;
                push_result(DISK_NONE, '0, 0, s, ST_OK, 1);
            end
            OP_RESIZE: begin
                s = lookup_extent(sec);
                if (s < 0) begin
                    push_result(DISK_NONE, '0, 0, 0, ST_NOT_CACHED, 1);
                    return;
                end
                make_newest(s);
                if (cnt != len_q[s]) begin
                    need = int'(held) - int'(len_q[s]) + int'(cnt);
                    while (need > int'(capacity)) begin
                        v = oldest_unlocked(s);
                        if (v < 0) begin
                            push_result(DISK_NONE, '0, 0, s, ST_NO_ROOM, 1);
                            return;
                        end
                        need -= int'(len_q[v]);
                        write_back_entry(v);
                        drop_entry(v);
                    end
                    // only growth reads the added tail
                    if (fill && cnt > len_q[s])
                        push_result(DISK_READ, start_q[s] + ADDR_W'(len_q[s]),
                                    int'(cnt) - int'(len_q[s]), s, ST_OK, 0);
                    len_q[s] = LEN_W'(cnt);
                    held = 16'(need);
                end
                push_result(DISK_NONE, '0, 0, s, ST_OK, 1);
            end
            OP_ACCESS: begin
                s = lookup_extent(sec);
                if (s < 0) begin
                    push_result(DISK_NONE, '0, 0, 0, ST_NOT_CACHED, 1);
                    return;
                end
                if (int'(off) + int'(cnt) > int'(len_q[s])) begin
                    push_result(DISK_NONE, '0, 0, s, ST_RANGE, 1);
                    return;
                end
                make_newest(s);
                if (off == 0 && cnt == 1) begin
                    if (!first_q[s]) begin
                        push_result(DISK_READ, start_q[s], 1, s, ST_OK, 0);
                        first_q[s] = 1;
                    end
                end else if (!whole_q[s]) begin
                    push_result(DISK_READ, start_q[s], int'(len_q[s]), s, ST_OK, 0);
                    first_q[s] = 1;
                    whole_q[s] = 1;
                end
                push_result(DISK_NONE, '0, 0, s, ST_OK, 1);
            end
            OP_MARK_DIRTY, OP_LOCK, OP_UNLOCK, OP_WB_ONE: begin
                s = lookup_extent(sec);
                if (s < 0) begin
                    push_result(DISK_NONE, '0, 0, 0, ST_NOT_CACHED, 1);
                    return;
                end
                if (op == OP_MARK_DIRTY) begin
                    dirty_q[s] = 1;
                end else if (op == OP_LOCK) begin
                    if (locks_q[s] == 8'hFF) begin
                        push_result(DISK_NONE, '0, 0, s, ST_LOCK_ERR, 1);
                        return;
                    end
                    locks_q[s]++;
                end else if (op == OP_UNLOCK) begin
                    if (locks_q[s] == 0) begin
                        push_result(DISK_NONE, '0, 0, s, ST_LOCK_ERR, 1);
                        return;
                    end
                    locks_q[s]--;
                end else begin
                    write_back_entry(s);
                end
                push_result(DISK_NONE, '0, 0, s, ST_OK, 1);
            end
            OP_INVALIDATE: begin
                // one probe per extent-sized step, at least one, address wraps
                probes = (int'(cnt) + MAX_EXTENT_SECTORS - 1) / MAX_EXTENT_SECTORS;
                if (probes == 0) probes = 1;
                for (int k = 0; k < probes; k++) begin
                    s = lookup_extent(sec + ADDR_W'(k * MAX_EXTENT_SECTORS));
                    if (s >= 0) drop_entry(s);
                end
                push_result(DISK_NONE, '0, 0, 0, ST_OK, 1);
            end
            OP_WB_ALL: begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (rank_q[i] == SLOT_W'(k) && valid_q[i]) write_back_entry(i);
                push_result(DISK_NONE, '0, 0, 0, ST_OK, 1);
            end
            default: push_result(DISK_NONE, '0, 0, 0, ST_OK, 1);
        endcase
    endfunction

    task automatic report_mismatch(string what, cache_result_t want, cache_result_t got);
        $display("[%0t] mismatch (%s): want op=%0d sec=%h cnt=%0d slot=%0d st=%0d last=%0d, got op=%0d sec=%h cnt=%0d slot=%0d st=%0d last=%0d",
                 $realtime, what, want.disk_op, want.disk_sector, want.disk_count, want.slot,
                 want.status, want.last, got.disk_op, got.disk_sector, got.disk_count,
                 got.slot, got.status, got.last);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        pending = 0;
        clear_table();
    end

    always @(posedge aclk) begin
        cache_result_t got, want;
        if (!aresetn) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                capacity = pwdata[15:0];
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[53:48],
                                s_tdata[54]);
            if (m_tvalid && m_tready) begin
                got.disk_op = m_tuser;
                got.disk_sector = m_tdata[31:0];
                got.disk_count = m_tdata[38:32];
                got.slot = m_tdata[42:39];
                got.status = m_tdata[45:43];
                got.last = m_tlast;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) report_mismatch("field", want, got);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/extent_buffer_cache_manager_unit_test.sv =====
// testbench top for extent_buffer_cache_manager_unit: clock, reset, requests, verdict
// depends on ebcm_pkg, the block and ebcm_result_checker
module extent_buffer_cache_manager_unit_test;
    import ebcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // start_sector[31:0], sector_count[47:32],
                            // sector_offset[53:48], fill_on_grow[54]
    logic [3:0]  s_tuser;   // opcode[3:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // disk_sector[31:0], disk_count[38:32],
                            // entry_slot[42:39], status[45:43]
    logic [1:0]  m_tuser;   // disk_op[1:0]
    logic        m_tlast;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int fail_count, pending, results_seen;
    int requests_sent, settings_used;
    int cycle_count;
    int out_hold;
    bit no_idle;               // phase with back-to-back traffic on both sides
    logic [31:0] addr_pool[24];

    extent_buffer_cache_manager_unit u_top (.*);

    ebcm_result_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // result side: after each transaction, back off a random number of cycles
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            n = draw_gap();
            out_hold <= n;
            m_tready <= (n == 0);
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            m_tready <= (out_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one request transaction; valid stays high across back-to-back items
    task automatic send_request(logic [3:0] op, logic [31:0] sec, logic [15:0] cnt,
                                logic [5:0] off, logic fill);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, fill, off, cnt, sec};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // wait for every result, then let the sequencer settle before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    // find most often and reuse a small set of extents so hits, evictions and errors recur
    task automatic random_request();
        logic [3:0]  op;
        logic [31:0] sec;
        logic [15:0] cnt;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_FIND;
        else if (pick < 40) op = OP_RESIZE;
        else if (pick < 55) op = OP_ACCESS;
        else if (pick < 63) op = OP_MARK_DIRTY;
        else if (pick < 70) op = OP_LOCK;
        else if (pick < 78) op = OP_UNLOCK;
        else if (pick < 85) op = OP_WB_ONE;
        else if (pick < 91) op = OP_INVALIDATE;
        else if (pick < 97) op = OP_WB_ALL;
        else                op = 4'($urandom_range(9, 15));
        sec = ($urandom_range(0, 19) == 0) ? $urandom() : addr_pool[$urandom_range(0, 23)];
        pick = $urandom_range(0, 9);
        if (pick == 0)      cnt = 16'($urandom_range(0, 65535));
        else if (pick == 1) cnt = 16'($urandom_range(0, 1));
        else if (op == OP_ACCESS || op == OP_INVALIDATE)
            cnt = 16'($urandom_range(0, 200));
        else                cnt = 16'($urandom_range(1, MAX_EXTENT_SECTORS));
        send_request(op, sec, cnt,
                     (op == OP_ACCESS && $urandom_range(0, 2) == 0) ? 6'd0
                                                                    : 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic new_address_pool();
        logic [31:0] base;
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FE00 : ($urandom() & ~32'h3F);
        for (int i = 0; i < 24; i++)
            addr_pool[i] = (i < 20) ? base + 32'(i * MAX_EXTENT_SECTORS) : $urandom();
    endtask

    initial begin
        logic [15:0] settings[6];
        settings = '{16'd1024, 16'd65535, 16'd1, 16'd100, 16'd64, 16'd200};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        requests_sent = 0;
        settings_used = 0;
        no_idle = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, every opcode, each corner the block names
        send_request(OP_FIND, 32'h0000_0000, 16'd0, 6'd0, 1'b0);          // zero length
        send_request(OP_FIND, 32'h0000_0000, 16'd65, 6'd0, 1'b0);         // too long
        send_request(OP_FIND, 32'h0000_0000, 16'd64, 6'd0, 1'b0);
        send_request(OP_FIND, 32'hFFFF_FFC0, 16'd64, 6'd0, 1'b0);
        send_request(OP_FIND, 32'h0000_0000, 16'd64, 6'd0, 1'b0);         // hit
        send_request(OP_FIND, 32'h1234_5678, 16'd10, 6'd0, 1'b0);
        send_request(OP_RESIZE, 32'hDEAD_BEEF, 16'd8, 6'd0, 1'b0);        // miss
        send_request(OP_RESIZE, 32'h1234_5678, 16'd10, 6'd0, 1'b1);       // same size
        send_request(OP_RESIZE, 32'h1234_5678, 16'd30, 6'd0, 1'b1);       // grow and read
        send_request(OP_RESIZE, 32'h1234_5678, 16'd20, 6'd0, 1'b1);       // shrink, no read
        send_request(OP_ACCESS, 32'h1234_5678, 16'hFFFF, 6'd63, 1'b1);    // beyond extent
        send_request(OP_ACCESS, 32'h1234_5678, 16'd1, 6'd0, 1'b0);        // first sector
        send_request(OP_ACCESS, 32'h1234_5678, 16'd0, 6'd5, 1'b0);        // zero count
        send_request(OP_MARK_DIRTY, 32'h1234_5678, 16'd0, 6'd0, 1'b0);
        send_request(OP_MARK_DIRTY, 32'h0000_0000, 16'd0, 6'd0, 1'b0);
        send_request(OP_UNLOCK, 32'h1234_5678, 16'd0, 6'd0, 1'b0);        // underflow
        send_request(OP_LOCK, 32'h1234_5678, 16'd0, 6'd0, 1'b0);
        send_request(OP_UNLOCK, 32'h1234_5678, 16'd0, 6'd0, 1'b0);
        send_request(OP_WB_ONE, 32'h1234_5678, 16'd0, 6'd0, 1'b0);
        send_request(OP_WB_ONE, 32'h7777_0000, 16'd0, 6'd0, 1'b0);        // not cached
        send_request(OP_WB_ALL, 32'h0, 16'd0, 6'd0, 1'b0);
        send_request(OP_INVALIDATE, 32'hFFFF_FFC0, 16'd128, 6'd0, 1'b0);  // wraps to zero
        send_request(OP_INVALIDATE, 32'h1234_5678, 16'd0, 6'd0, 1'b0);
        send_request(4'hF, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F, 1'b1);         // unknown opcode
        // pinned extent: stays locked until an invalidate hits it
        send_request(OP_FIND, 32'h0000_4000, 16'd4, 6'd0, 1'b0);
        for (int i = 0; i < 3; i++)
            send_request(OP_LOCK, 32'h0000_4000, 16'd0, 6'd0, 1'b0);
        drain();

        // random phases, one per capacity setting, extremes included
        foreach (settings[p]) begin
            if (p > 0) write_capacity(settings[p]);
            no_idle = (p % 3 == 2);
            new_address_pool();
            for (int i = 0; i < 37; i++) random_request();
            drain();
        end

        $display("covered %0d requests, %0d results, %0d capacity settings after reset",
                 requests_sent, results_seen, settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
